// ===== sv/bi2c_pkg.sv =====
// Shared types and constants for the bit-banged I2C register master.
// Holds the channel payload structs, the function codes and the queue item.
// No dependencies.
package bi2c_pkg;

  localparam int unsigned MAX_BURST = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_AW      = 1;
  localparam int unsigned Q_CW      = 2;

  localparam logic [1:0] FN_TICK  = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_WRITE = 2'd2;
  localparam logic [1:0] FN_BURST = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_WA_NACK  = 2'd1;
  localparam logic [1:0] ST_RA_NACK  = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       register_index;
    logic [7:0]       write_value;
    logic [LEN_W-1:0] burst_length;
    logic             sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       done_res;
    logic [1:0] status;
    logic       command_rejected;
  } out_item_t;

  typedef struct packed {
    logic             is_cmd;
    logic [1:0]       op;
    logic [7:0]       reg_idx;
    logic [7:0]       wval;
    logic [LEN_W-1:0] len;
    logic             sda;
  } q_item_t;

endpackage

// ===== sv/bitbang_i2c_register_master.sv =====
// Top level: bit-banged I2C register master with decoupled front and back.
// An item's result passes through the queue and then the output register.
// Throughput: one queued item per cycle through the phase sequencer while out_stall is low.
// Input stall rises when the two-entry queue is full behind a stalled output.
// Reset (rst_n low, synchronous): bus idle with both lines released, queue empty,
// device address 106.
module bitbang_i2c_register_master (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  bi2c_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bi2c_pkg::out_item_t out_data
);
  import bi2c_pkg::*;

  logic [6:0] dev_addr_r;
  logic       q_valid;
  logic       q_pop;
  q_item_t    q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd106;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
    end
  end

  bi2c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bi2c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.command_rejected |-> out_data.busy_res)
    else $error("rejected command while bus idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && out_data.scl_release
      && out_data.sda_release)
    else $error("done without released idle bus");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.done_res)
    else $error("status outside done");

  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid && !out_data.done_res |-> out_data.busy_res
      && out_data.scl_release)
    else $error("read byte outside ack slot");

endmodule

// ===== sv/bi2c_front.sv =====
// Front end: classifies input items and buffers them in a two-entry queue.
// Depends on bi2c_pkg.
module bi2c_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bi2c_pkg::in_item_t in_data,
  output logic               q_valid,
  output bi2c_pkg::q_item_t  q_item,
  input  logic               q_pop
);
  import bi2c_pkg::*;

  q_item_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]     cnt_r, cnt_nxt;
  q_item_t             cls;
  logic                push;
  logic                pop;

  always_comb begin
    cls.is_cmd  = (in_data.func != FN_TICK);
    cls.op      = in_data.func;
    cls.reg_idx = in_data.register_index;
    cls.wval    = in_data.write_value;
    cls.sda     = in_data.sda_level;
    if (in_data.func == FN_BURST) begin
      if (in_data.burst_length == '0) begin
        cls.len = LEN_W'(1);
      end else if (in_data.burst_length > LEN_W'(MAX_BURST)) begin
        cls.len = LEN_W'(MAX_BURST);
      end else begin
        cls.len = in_data.burst_length;
      end
    end else begin
      cls.len = LEN_W'(1);
    end
  end

  assign in_stall = (cnt_r == Q_CW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/bi2c_back.sv =====
// Back end: bus phase sequencer that executes one queued item per cycle
// if out_stall is low. Holds the output register. Depends on bi2c_pkg.
module bi2c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          dev_addr,
  input  logic                q_valid,
  input  bi2c_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bi2c_pkg::out_item_t out_data
);
  import bi2c_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C, PH_STOP_A, PH_STOP_B, PH_STOP_C,
    PH_WBIT_LO, PH_WBIT_HI, PH_WACK_LO, PH_WACK_HI, PH_WACK_END,
    PH_RBIT_LO, PH_RBIT_HI, PH_RACK_LO, PH_RACK_HI
  } phase_t;

  typedef enum logic [2:0] {
    K_START, K_WA, K_WREG, K_WVAL, K_RA, K_RD, K_STOP
  } kind_t;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] sh;
  } entry_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [3:0]       bitc_r, bitc_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [7:0]       sreg_r, sreg_nxt;
  logic [7:0]       sval_r, sval_nxt;
  logic [1:0]       rstat_r, rstat_nxt;
  logic [1:0]       lines_r, lines_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             take;
  kind_t            kind;
  entry_t           ent;
  logic [2:0]       ent_step;
  logic [LEN_W-1:0] rem_dec;
  logic             rem_le1;

  function automatic kind_t kind_of(input logic [1:0] op, input logic [2:0] s);
    kind_t k;
    k = K_STOP;
    case (s)
      3'd0: k = K_START;
      3'd1: k = K_WA;
      3'd2: k = K_WREG;
      3'd3: k = (op == FN_WRITE) ? K_WVAL : K_START;
      3'd4: k = (op == FN_WRITE) ? K_STOP : K_RA;
      3'd5: k = (op == FN_WRITE) ? K_STOP : K_RD;
      default: k = K_STOP;
    endcase
    return k;
  endfunction

  function automatic entry_t enter(input kind_t k, input logic [6:0] addr,
                                   input logic [7:0] rg, input logic [7:0] vl,
                                   input logic [7:0] sh);
    entry_t e;
    e.sh = sh;
    e.ph = PH_WBIT_LO;
    case (k)
      K_START: e.ph = PH_START_A;
      K_STOP:  e.ph = PH_STOP_A;
      K_WA:    e.sh = {addr, 1'b0};
      K_WREG:  e.sh = rg;
      K_WVAL:  e.sh = vl;
      K_RA:    e.sh = {addr, 1'b1};
      default: begin
        e.sh = '0;
        e.ph = PH_RBIT_LO;
      end
    endcase
    return e;
  endfunction

  assign take      = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign kind      = kind_of(op_r, step_r);
  assign rem_le1   = (rem_r <= LEN_W'(1));
  assign rem_dec   = (rem_r != '0) ? rem_r - LEN_W'(1) : '0;

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    bitc_nxt  = bitc_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    op_nxt    = op_r;
    sreg_nxt  = sreg_r;
    sval_nxt  = sval_r;
    rstat_nxt = rstat_r;
    lines_nxt = lines_r;
    ent_step  = step_r + 3'd1;
    ent       = enter(kind_of(op_r, ent_step), dev_addr, sreg_r, sval_r, shift_r);
    out_nxt   = '0;
    out_valid_nxt = out_valid_r && out_stall;

    if (q_pop) begin
      out_valid_nxt = 1'b1;
      if (q_item.is_cmd) begin
        if (phase_r != PH_IDLE) begin
          out_nxt.command_rejected = 1'b1;
        end else begin
          op_nxt    = q_item.op;
          sreg_nxt  = q_item.reg_idx;
          sval_nxt  = q_item.wval;
          rem_nxt   = q_item.len;
          rstat_nxt = ST_OK;
          step_nxt  = '0;
          bitc_nxt  = '0;
          ent       = enter(kind_of(q_item.op, 3'd0), dev_addr, q_item.reg_idx,
                            q_item.wval, shift_r);
          phase_nxt = ent.ph;
          shift_nxt = ent.sh;
        end
      end else begin
        case (phase_r)
          PH_IDLE: ;
          PH_START_A: begin
            lines_nxt = 2'b11;
            phase_nxt = PH_START_B;
          end
          PH_START_B: begin
            lines_nxt = 2'b10;
            phase_nxt = PH_START_C;
          end
          PH_START_C: begin
            lines_nxt = 2'b00;
            step_nxt  = ent_step;
            bitc_nxt  = '0;
            phase_nxt = ent.ph;
            shift_nxt = ent.sh;
          end
          PH_STOP_A: begin
            lines_nxt = 2'b00;
            phase_nxt = PH_STOP_B;
          end
          PH_STOP_B: begin
            lines_nxt = 2'b10;
            phase_nxt = PH_STOP_C;
          end
          PH_STOP_C: begin
            lines_nxt        = 2'b11;
            phase_nxt        = PH_IDLE;
            out_nxt.done_res = 1'b1;
            out_nxt.status   = rstat_r;
            if (op_r == FN_READ && rstat_r != ST_OK) begin
              out_nxt.byte_valid = 1'b1;
              out_nxt.last_byte  = 1'b1;
            end
          end
          PH_WBIT_LO: begin
            lines_nxt = {1'b0, shift_r[7]};
            phase_nxt = PH_WBIT_HI;
          end
          PH_WBIT_HI: begin
            lines_nxt = {1'b1, shift_r[7]};
            shift_nxt = {shift_r[6:0], 1'b0};
            bitc_nxt  = bitc_r + 4'd1;
            phase_nxt = (bitc_r >= 4'd7) ? PH_WACK_LO : PH_WBIT_LO;
          end
          PH_WACK_LO: begin
            lines_nxt = 2'b01;
            phase_nxt = PH_WACK_HI;
          end
          PH_WACK_HI: begin
            lines_nxt = 2'b11;
            if (q_item.sda) begin
              if (kind == K_WA) begin
                rstat_nxt = ST_WA_NACK;
              end else if (kind == K_RA) begin
                rstat_nxt = ST_RA_NACK;
              end
            end
            phase_nxt = PH_WACK_END;
          end
          PH_WACK_END: begin
            lines_nxt = 2'b01;
            if ((kind == K_WA && rstat_r == ST_WA_NACK && op_r != FN_WRITE) ||
                (kind == K_RA && rstat_r == ST_RA_NACK)) begin
              ent_step = (op_r == FN_WRITE) ? 3'd4 : 3'd6;
              ent = enter(kind_of(op_r, ent_step), dev_addr, sreg_r, sval_r, shift_r);
            end
            step_nxt  = ent_step;
            bitc_nxt  = '0;
            phase_nxt = ent.ph;
            shift_nxt = ent.sh;
          end
          PH_RBIT_LO: begin
            lines_nxt = 2'b01;
            phase_nxt = PH_RBIT_HI;
          end
          PH_RBIT_HI: begin
            lines_nxt = 2'b11;
            shift_nxt = {shift_r[6:0], q_item.sda};
            bitc_nxt  = bitc_r + 4'd1;
            phase_nxt = (bitc_r >= 4'd7) ? PH_RACK_LO : PH_RBIT_LO;
          end
          PH_RACK_LO: begin
            lines_nxt = {1'b0, rem_le1};
            phase_nxt = PH_RACK_HI;
          end
          PH_RACK_HI: begin
            lines_nxt          = {1'b1, rem_le1};
            out_nxt.read_byte  = shift_r;
            out_nxt.byte_valid = 1'b1;
            out_nxt.last_byte  = rem_le1;
            rem_nxt            = rem_dec;
            if (rem_dec != '0) begin
              bitc_nxt  = '0;
              shift_nxt = '0;
              phase_nxt = PH_RBIT_LO;
            end else begin
              step_nxt  = ent_step;
              bitc_nxt  = '0;
              phase_nxt = ent.ph;
              shift_nxt = ent.sh;
            end
          end
          default: begin
            lines_nxt = 2'b11;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      out_nxt.scl_release = lines_nxt[1];
      out_nxt.sda_release = lines_nxt[0];
      out_nxt.busy_res    = (phase_nxt != PH_IDLE);
    end else begin
      out_nxt = out_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= '0;
      bitc_r      <= '0;
      shift_r     <= '0;
      rem_r       <= '0;
      op_r        <= '0;
      sreg_r      <= '0;
      sval_r      <= '0;
      rstat_r     <= ST_OK;
      lines_r     <= 2'b11;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      bitc_r      <= bitc_nxt;
      shift_r     <= shift_nxt;
      rem_r       <= rem_nxt;
      op_r        <= op_nxt;
      sreg_r      <= sreg_nxt;
      sval_r      <= sval_nxt;
      rstat_r     <= rstat_nxt;
      lines_r     <= lines_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
